// ----- hw/rtl/rmfh_pkg.sv -----
// Shared types and constants for the recursive mutex with FIFO handoff.
// Holds field widths and status codes; it depends on nothing else.
`default_nettype none

package rmfh_pkg;

    // Field widths of the request and result transactions.
    localparam int TID_W   = 6;
    localparam int DEPTH_W = 8;

    // The recursion depth never grows past what one byte holds.
    localparam int DEPTH_CEIL = 255;

    typedef logic [2:0] status_t;

    // Result status codes.
    localparam status_t ST_GRANTED    = 3'd0;
    localparam status_t ST_QUEUED     = 3'd1;
    localparam status_t ST_LOWERED    = 3'd2;
    localparam status_t ST_HANDOFF    = 3'd3;
    localparam status_t ST_FREE       = 3'd4;
    localparam status_t ST_OVERFLOW   = 3'd5;
    localparam status_t ST_NOT_HOLDER = 3'd6;
    localparam status_t ST_QUEUE_FULL = 3'd7;

    // Request kinds.
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

endpackage

`default_nettype wire

// ----- hw/rtl/recursive_mutex_fifo_handoff.sv -----
// Top level of the recursive mutex with a FIFO wait queue and direct handoff.
// Depends on rmfh_pkg for widths and status codes.
//
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the request kind
//   (acquire or release), tdata carries the thread number. Every request
//   produces exactly one result transaction on the m_axis channel with the
//   status code in tuser and the lock state after the request in tdata.
//   The cfg channel writes the recursive_mode bit; it is always ready and is
//   meant to be written only while no request is in flight.
//   A request accepted at a clock edge sits in the input register, and the
//   decision logic behind it loads the result register as soon as that is
//   free or being taken; the result is offered from that register.
//   Throughput: one request per cycle while the receiver keeps taking results,
//   set by the single decision stage; the wait queue memory keeps the entry
//   behind the head prefetched so a handoff never waits for a read.
//   Reset frees the lock, empties the wait queue and clears recursive_mode.
//   The queue memory is not cleared; only entries written are ever read.
//   When the receiver stalls, the result is held, one more request is taken
//   into the input register, and then s_axis_tready drops until the result
//   is taken.
`default_nettype none

module recursive_mutex_fifo_handoff #(
    parameter int QUEUE_SLOTS   = 64,
    parameter int MAX_RECURSION = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration write: recursive_mode in bit 0.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,

    // Request stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [5:0] thread_id, [7:6] zero
    input  wire logic        s_axis_tuser,   // [0] req_type

    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [0] woken_valid, [6:1] woken_thread,
                                             // [7] locked, [13:8] owner_thread,
                                             // [21:14] owner_depth, [23:22] zero
    output rmfh_pkg::status_t m_axis_tuser   // [2:0] status
);

    import rmfh_pkg::*;

    localparam int PTR_W     = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CNT_W     = $clog2(QUEUE_SLOTS + 1);
    localparam int LIMIT_REC = (MAX_RECURSION > DEPTH_CEIL) ? DEPTH_CEIL :
                               ((MAX_RECURSION < 1) ? 1 : MAX_RECURSION);

    // Advance a ring pointer with wraparound.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_SLOTS - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    // Configuration.
    logic                 mode_reg;

    // Input register.
    logic                 in_valid_reg;
    logic                 in_req_reg;
    logic [TID_W-1:0]     in_tid_reg;

    // Lock state.
    logic                 holder_valid_reg, holder_valid_next;
    logic [TID_W-1:0]     holder_id_reg, holder_id_next;
    logic [DEPTH_W-1:0]   hold_depth_reg, hold_depth_next;

    // Wait queue.
    logic [TID_W-1:0]     ring_mem [QUEUE_SLOTS];
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TID_W-1:0]     head_val_reg, head_val_next;
    logic [TID_W-1:0]     behind_reg;
    logic [PTR_W-1:0]     rd_addr;
    logic                 push;
    logic                 pop;

    // Result register.
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic                 out_woken_valid_reg;
    logic [TID_W-1:0]     out_woken_thread_reg;
    logic                 out_locked_reg;
    logic [TID_W-1:0]     out_owner_reg;
    logic [DEPTH_W-1:0]   out_depth_reg;

    // Decision stage signals.
    logic                 advance;
    logic                 is_holder;
    logic [DEPTH_W-1:0]   depth_limit;
    status_t              status;
    logic                 woken_valid;
    logic [TID_W-1:0]     woken_thread;

    // Handshakes: the decision stage moves when the result register is free.
    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_data;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_req_reg <= s_axis_tuser;
            in_tid_reg <= s_axis_tdata[TID_W-1:0];
        end
    end

    // Decide the outcome of the request and the next lock and queue state.
    always_comb
    begin
        is_holder   = holder_valid_reg && (holder_id_reg == in_tid_reg);
        depth_limit = mode_reg ? DEPTH_W'(LIMIT_REC) : DEPTH_W'(1);

        holder_valid_next = holder_valid_reg;
        holder_id_next    = holder_id_reg;
        hold_depth_next   = hold_depth_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        head_val_next     = head_val_reg;
        push              = 1'b0;
        pop               = 1'b0;
        woken_valid       = 1'b0;
        woken_thread      = '0;
        status            = ST_NOT_HOLDER;

        if (in_req_reg == REQ_ACQUIRE)
        begin
            if (is_holder)
            begin
                if (hold_depth_reg < depth_limit)
                begin
                    hold_depth_next = hold_depth_reg + 1'b1;
                    status          = ST_GRANTED;
                end
                else
                begin
                    status = ST_OVERFLOW;
                end
            end
            else if (!holder_valid_reg)
            begin
                holder_valid_next = 1'b1;
                holder_id_next    = in_tid_reg;
                hold_depth_next   = DEPTH_W'(1);
                status            = ST_GRANTED;
            end
            else if (count_reg == CNT_W'(QUEUE_SLOTS))
            begin
                status = ST_QUEUE_FULL;
            end
            else
            begin
                push       = 1'b1;
                tail_next  = ptr_inc(tail_reg);
                count_next = count_reg + 1'b1;
                status     = ST_QUEUED;
                // A thread entering an empty queue becomes the head.
                if (count_reg == '0)
                    head_val_next = in_tid_reg;
            end
        end
        else
        begin
            if (!is_holder)
            begin
                status = ST_NOT_HOLDER;
            end
            else if (hold_depth_reg > DEPTH_W'(1))
            begin
                hold_depth_next = hold_depth_reg - 1'b1;
                status          = ST_LOWERED;
            end
            else if (count_reg != '0)
            begin
                pop             = 1'b1;
                head_next       = ptr_inc(head_reg);
                count_next      = count_reg - 1'b1;
                head_val_next   = behind_reg;
                holder_id_next  = head_val_reg;
                hold_depth_next = DEPTH_W'(1);
                woken_valid     = 1'b1;
                woken_thread    = head_val_reg;
                status          = ST_HANDOFF;
            end
            else
            begin
                holder_valid_next = 1'b0;
                holder_id_next    = '0;
                hold_depth_next   = '0;
                status            = ST_FREE;
            end
        end

        // Entry behind the head as of the next cycle, for the prefetch read.
        rd_addr = ptr_inc(advance ? head_next : head_reg);
    end

    // Lock and queue state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holder_valid_reg <= 1'b0;
            holder_id_reg    <= '0;
            hold_depth_reg   <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
        end
        else if (advance)
        begin
            holder_valid_reg <= holder_valid_next;
            holder_id_reg    <= holder_id_next;
            hold_depth_reg   <= hold_depth_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            count_reg        <= count_next;
        end
    end

    // Wait queue memory: write at the tail, registered read of the entry
    // behind the head, bypassing a write to that same entry.
    always_ff @(posedge clk)
    begin
        if (advance && push)
            ring_mem[tail_reg] <= in_tid_reg;
        if (advance && push && (tail_reg == rd_addr))
            behind_reg <= in_tid_reg;
        else
            behind_reg <= ring_mem[rd_addr];
        if (advance)
            head_val_reg <= head_val_next;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg       <= status;
            out_woken_valid_reg  <= woken_valid;
            out_woken_thread_reg <= woken_thread;
            out_locked_reg       <= holder_valid_next;
            out_owner_reg        <= holder_id_next;
            out_depth_reg        <= hold_depth_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {2'b00, out_depth_reg, out_owner_reg, out_locked_reg,
                            out_woken_thread_reg, out_woken_valid_reg};

    // The queue never holds more than its slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_SLOTS))
        else $error("wait queue count exceeds its slots");

    // A free lock has no owner and no depth.
    a_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !holder_valid_reg |-> (hold_depth_reg == '0) && (holder_id_reg == '0))
        else $error("free lock carries owner or depth");

    // A held lock always has a nonzero depth.
    a_held_depth: assert property (@(posedge clk) disable iff (!rst_n)
        holder_valid_reg |-> (hold_depth_reg != '0))
        else $error("held lock with zero depth");

    // A woken thread is reported exactly on a handoff.
    a_woken_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_woken_valid_reg == (out_status_reg == ST_HANDOFF)))
        else $error("woken flag disagrees with status");

    // A handoff leaves the lock held at depth one.
    a_handoff_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && pop) |=> holder_valid_reg && (hold_depth_reg == DEPTH_W'(1)))
        else $error("handoff did not leave depth one");

endmodule

`default_nettype wire

// ----- tb/sv/rmfh_checker.sv -----
// Scoreboard for the recursive mutex: it watches the config, request and result channels.
// It keeps its own model of the lock and the wait queue and compares every result.
// Depends on rmfh_pkg for widths and status codes.
`timescale 1ns / 1ps

module rmfh_checker #(
    parameter int QUEUE_SLOTS   = 64,
    parameter int MAX_RECURSION = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_data,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [5:0] thread_id, [7:6] zero
    input  wire logic        s_axis_tuser,   // [0] req_type
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata,   // [0] woken_valid, [6:1] woken_thread,
                                             // [7] locked, [13:8] owner_thread,
                                             // [21:14] owner_depth, [23:22] zero
    input  wire logic [2:0]  m_axis_tuser,   // [2:0] status
    output int               fail_count,
    output int               pending,
    output int               results_checked,
    output int               handoff_hits,
    output int               overflow_hits,
    output int               queue_full_hits,
    output int               not_holder_hits,
    output logic             locked_now,
    output logic [5:0]       holder_now
);
    import rmfh_pkg::*;

    // The depth can never pass what one byte holds.
    localparam int DEPTH_CAP = (MAX_RECURSION > DEPTH_CEIL) ? DEPTH_CEIL : MAX_RECURSION;

    typedef struct packed {
        status_t                status;
        logic                   woken_valid;
        logic [TID_W-1:0]       woken_thread;
        logic                   locked;
        logic [TID_W-1:0]       owner;
        logic [DEPTH_W-1:0]     depth;
    } lock_result_t;

    // Shadow copy of the lock, its wait queue and the mode register.
    logic               mode_q;
    logic               held_q;
    logic [TID_W-1:0]   owner_q;
    logic [DEPTH_W-1:0] depth_q;
    logic [TID_W-1:0]   wait_slots [QUEUE_SLOTS];
    int                 head_q;
    int                 tail_q;
    int                 waiters_q;

    lock_result_t       awaited_results [$];
    lock_result_t       seen_result;
    lock_result_t       due_result;
    lock_result_t       next_result;

    assign locked_now = held_q;
    assign holder_now = owner_q;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns, result %0d: %s", $time, results_checked, msg);
        fail_count++;
    endtask

    // Apply one request to the shadow lock and work out the result it must give.
    task automatic resolve_request(input logic req, input logic [TID_W-1:0] tid,
                                   output lock_result_t r);
        int limit;
        limit = mode_q ? DEPTH_CAP : 1;
        r = '0;
        if (req == REQ_ACQUIRE)
        begin
            if (held_q && owner_q == tid)
            begin
                if (depth_q < limit)
                begin
                    depth_q++;
                    r.status = ST_GRANTED;
                end
                else
                begin
                    r.status = ST_OVERFLOW;
                end
            end
            else if (!held_q)
            begin
                held_q  = 1'b1;
                owner_q = tid;
                depth_q = 1;
                r.status = ST_GRANTED;
            end
            else if (waiters_q >= QUEUE_SLOTS)
            begin
                r.status = ST_QUEUE_FULL;
            end
            else
            begin
                wait_slots[tail_q] = tid;
                tail_q = (tail_q + 1) % QUEUE_SLOTS;
                waiters_q++;
                r.status = ST_QUEUED;
            end
        end
        else
        begin
            if (!held_q || owner_q != tid)
            begin
                r.status = ST_NOT_HOLDER;
            end
            else if (depth_q > 1)
            begin
                depth_q--;
                r.status = ST_LOWERED;
            end
            else if (waiters_q > 0)
            begin
                // Ownership goes straight to the oldest waiter.
                owner_q = wait_slots[head_q];
                head_q = (head_q + 1) % QUEUE_SLOTS;
                waiters_q--;
                depth_q = 1;
                r.woken_valid  = 1'b1;
                r.woken_thread = owner_q;
                r.status = ST_HANDOFF;
            end
            else
            begin
                held_q  = 1'b0;
                owner_q = '0;
                depth_q = '0;
                r.status = ST_FREE;
            end
        end
        r.locked = held_q;
        r.owner  = held_q ? owner_q : '0;
        r.depth  = held_q ? depth_q : '0;
    endtask

    // Compare one observed result with the oldest prediction, field by field.
    task automatic check_result(input lock_result_t got, input lock_result_t want);
        if (got.status !== want.status)
            report_mismatch($sformatf("status expected %0d, got %0d", want.status, got.status));
        if (got.woken_valid !== want.woken_valid)
            report_mismatch($sformatf("woken_valid expected %0d, got %0d",
                                      want.woken_valid, got.woken_valid));
        if (got.woken_thread !== want.woken_thread)
            report_mismatch($sformatf("woken_thread expected %0d, got %0d",
                                      want.woken_thread, got.woken_thread));
        if (got.locked !== want.locked)
            report_mismatch($sformatf("locked expected %0d, got %0d", want.locked, got.locked));
        if (got.owner !== want.owner)
            report_mismatch($sformatf("owner_thread expected %0d, got %0d",
                                      want.owner, got.owner));
        if (got.depth !== want.depth)
            report_mismatch($sformatf("owner_depth expected %0d, got %0d",
                                      want.depth, got.depth));
        case (want.status)
            ST_HANDOFF:    handoff_hits++;
            ST_OVERFLOW:   overflow_hits++;
            ST_QUEUE_FULL: queue_full_hits++;
            ST_NOT_HOLDER: not_holder_hits++;
            default:       ;
        endcase
        results_checked++;
    endtask

    // Every transaction on the three channels is handled at the edge that accepts it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q    = 1'b0;
            held_q    = 1'b0;
            owner_q   = '0;
            depth_q   = '0;
            head_q    = 0;
            tail_q    = 0;
            waiters_q = 0;
            awaited_results.delete();
            pending   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mode_q = cfg_data;

            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_result.status       = m_axis_tuser;
                seen_result.woken_valid  = m_axis_tdata[0];
                seen_result.woken_thread = m_axis_tdata[6:1];
                seen_result.locked       = m_axis_tdata[7];
                seen_result.owner        = m_axis_tdata[13:8];
                seen_result.depth        = m_axis_tdata[21:14];
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("result arrived with no request outstanding");
                end
                else
                begin
                    due_result = awaited_results.pop_front();
                    check_result(seen_result, due_result);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                resolve_request(s_axis_tuser, s_axis_tdata[5:0], next_result);
                awaited_results.push_back(next_result);
            end

            pending = awaited_results.size();
        end
    end

    initial
    begin
        fail_count      = 0;
        results_checked = 0;
        handoff_hits    = 0;
        overflow_hits   = 0;
        queue_full_hits = 0;
        not_holder_hits = 0;
    end

endmodule

// ----- tb/sv/recursive_mutex_fifo_handoff_test.sv -----
// Top of the recursive mutex testbench: clock, reset, request and config stimulus.
// It instantiates the block and the rmfh_checker scoreboard and gives the verdict.
// Depends on rmfh_pkg, rmfh_checker and recursive_mutex_fifo_handoff.
`timescale 1ns / 1ps

module recursive_mutex_fifo_handoff_test;
    import rmfh_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 4;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_data      = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tuser  = REQ_ACQUIRE;
    logic        m_axis_tready = 1'b0;
    wire         cfg_ready;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire [23:0]  m_axis_tdata;
    wire [2:0]   m_axis_tuser;

    int          send_idle_pct = 24;
    int          recv_idle_pct = 74;
    logic        hold_off_req  = 1'b0;
    int          requests_sent = 0;
    int          mode_writes   = 0;

    int          fail_count;
    int          pending;
    int          results_checked;
    int          handoff_hits;
    int          overflow_hits;
    int          queue_full_hits;
    int          not_holder_hits;
    logic        locked_now;
    logic [5:0]  holder_now;

    recursive_mutex_fifo_handoff uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rmfh_checker lock_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .handoff_hits    (handoff_hits),
        .overflow_hits   (overflow_hits),
        .queue_full_hits (queue_full_hits),
        .not_holder_hits (not_holder_hits),
        .locked_now      (locked_now),
        .holder_now      (holder_now)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reset is held at the start and never again.
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Result receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req  = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one request transaction and return at the falling edge after it is taken.
    // tvalid stays high so that back-to-back requests need no gap.
    task automatic send_request(input logic req, input logic [5:0] tid);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = {2'b00, tid};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic acquire(input logic [5:0] tid);
        send_request(REQ_ACQUIRE, tid);
    endtask

    task automatic release_lock(input logic [5:0] tid);
        send_request(REQ_RELEASE, tid);
    endtask

    // Stop offering requests and wait until every result has come back.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write recursive_mode once the block is idle.
    task automatic write_mode(input logic mode);
        drain();
        cfg_valid = 1'b1;
        cfg_data  = mode;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        mode_writes++;
    endtask

    // Main stimulus.
    initial
    begin
        int         blk;
        int         n;
        int         pick;
        int         pool_size;
        logic [5:0] pool_base;
        logic [5:0] tid;

        wait (rst_n == 1'b1);
        @(negedge clk);

        // Directed: non-recursive mode, queueing, repeated waits and handoffs.
        write_mode(1'b0);
        release_lock(6'd0);        // release while free
        acquire(6'd0);             // grant on a free lock
        acquire(6'd0);             // depth limit of one
        acquire(6'd63);            // waits
        acquire(6'd63);            // same thread queued twice
        release_lock(6'd21);       // release by a thread that does not hold it
        acquire(6'd42);
        release_lock(6'd0);        // hand off to 63
        release_lock(6'd63);       // hand off to 63 again
        release_lock(6'd63);       // hand off to 42
        release_lock(6'd42);       // lock becomes free

        // Directed: recursion in recursive mode.
        write_mode(1'b1);
        acquire(6'd42);
        acquire(6'd42);
        acquire(6'd42);
        release_lock(6'd42);
        acquire(6'd0);
        release_lock(6'd42);
        release_lock(6'd42);       // hand off to 0
        release_lock(6'd0);

        // Depth up to the byte limit, one more to overflow, then clear the mode
        // while the lock is held deep and unwind it.
        for (n = 0; n < 256; n++)
            acquire(6'd21);
        write_mode(1'b0);
        acquire(6'd21);
        for (n = 0; n < 255; n++)
            release_lock(6'd21);

        // Fill the wait queue and push one more, then unwind by handoffs.
        acquire(6'd7);
        for (n = 0; n < 65; n++)
            acquire(6'(($urandom_range(62) + 8) % 64));
        while (locked_now)
            release_lock(holder_now);

        // Random part: mostly well-formed traffic around a small pool of threads,
        // with some stray releases and fully random requests as noise.
        for (blk = 0; blk < 10; blk++)
        begin
            write_mode(blk[0]);
            if (blk == 4)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 24;
                hold_off_req  = 1'b1;
            end
            else if (blk == 7)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pool_base = 6'($urandom_range(63));
            pool_size = $urandom_range(8, 2);
            for (n = 0; n < 100; n++)
            begin
                pick = $urandom_range(99);
                tid  = pool_base + 6'($urandom_range(pool_size - 1));
                if (pick < 40 && locked_now)
                    release_lock(holder_now);
                else if (pick < 55 && locked_now)
                    acquire(holder_now);
                else if (pick < 88)
                    acquire(tid);
                else if (pick < 94)
                    release_lock(tid);
                else
                    send_request(1'($urandom_range(1)), 6'($urandom_range(63)));
            end
        end

        drain();
        $display("Run covered %0d requests and %0d mode writes; %0d results checked.",
                 requests_sent, mode_writes, results_checked);
        $display("Seen: %0d handoffs, %0d depth overflows, %0d queue full, %0d not holder.",
                 handoff_hits, overflow_hits, queue_full_hits, not_holder_hits);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #4_000_000;
        $display("Watchdog expired with %0d results outstanding.", pending);
        $display("Test completed with failures");
        $finish;
    end

endmodule
